/* sv/heading_dependent_motion_limits_macros.svh */
// assertion macros for the heading dependent motion limits block
`ifndef HEADING_DEPENDENT_MOTION_LIMITS_MACROS_SVH
`define HEADING_DEPENDENT_MOTION_LIMITS_MACROS_SVH

`ifndef SYNTHESIS
`define HDML_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hdml assertion failed");
`define HDML_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("hdml forbidden condition seen");
`else
`define HDML_ASSERT(lbl, prop)
`define HDML_NEVER(lbl, cond)
`endif

`endif

/* sv/hdml_pkg.sv */
// shared constants and types for the heading dependent motion limits block
package hdml_pkg;

  localparam int unsigned SECTOR_DEGREES   = 45;
  localparam int unsigned UNITS_PER_DEGREE = 128;
  localparam int unsigned SECTOR_UNITS     = SECTOR_DEGREES * UNITS_PER_DEGREE;

  localparam int unsigned ANGLE_W    = 17;
  localparam int unsigned RATE_W     = 16;
  localparam int unsigned LIM_W      = 16;
  localparam int unsigned NUM_LIMITS = 3;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam int unsigned LIM_SPEED = 0;
  localparam int unsigned LIM_ACCEL = 1;
  localparam int unsigned LIM_DECEL = 2;

  // angle magnitude reaches 2^(ANGLE_W-1)
  localparam int unsigned MAG_W        = ANGLE_W;
  localparam int unsigned C_W          = $clog2(SECTOR_UNITS + 1);
  localparam int unsigned FOLD_RECIP   = (1 << MAG_W) / SECTOR_UNITS;
  localparam int unsigned FOLD_RECIP_W = $clog2(FOLD_RECIP + 1);
  localparam int unsigned FOLD_Q_W     = $clog2((1 << (MAG_W - 1)) / SECTOR_UNITS + 1);

  // interpolation numerator and its reciprocal scale
  localparam int unsigned NUM_W          = LIM_W + C_W;
  localparam int unsigned INTERP_RECIP   = int'((64'd1 << NUM_W) / SECTOR_UNITS);
  localparam int unsigned INTERP_RECIP_W = $clog2(INTERP_RECIP + 1);

  localparam int unsigned FRONT_STAGES = 7;
  localparam int unsigned DIV_STEPS    = LIM_W;

  // queue depths are powers of two so the pointers wrap on their own
  localparam int unsigned MQ_DEPTH = 4;
  localparam int unsigned MQ_PTR_W = $clog2(MQ_DEPTH);
  localparam int unsigned MQ_CNT_W = $clog2(MQ_DEPTH + 1);
  localparam int unsigned OQ_DEPTH = 2;
  localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED_STRAIGHT = 3'd0,
    REG_SPEED_DIAGONAL = 3'd1,
    REG_ACCEL_STRAIGHT = 3'd2,
    REG_ACCEL_DIAGONAL = 3'd3,
    REG_DECEL_STRAIGHT = 3'd4,
    REG_DECEL_DIAGONAL = 3'd5,
    REG_TURN_RATE_LIM  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [LIM_W-1:0] straight;
    logic [LIM_W-1:0] diagonal;
  } lim_pair_t;

  typedef lim_pair_t [NUM_LIMITS-1:0] lim_cfg_t;

  typedef struct packed {
    logic [NUM_LIMITS-1:0][LIM_W-1:0] lim;
    logic [RATE_W-1:0]                w;
  } mid_item_t;

  typedef struct packed {
    logic [NUM_LIMITS-1:0][LIM_W-1:0] lim;
  } out_item_t;

endpackage

/* sv/hdml_front.sv */
// front pipeline: angle fold and interpolation of the three limits
module hdml_front import hdml_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic signed [ANGLE_W-1:0] heading_angle_i,
  input  logic signed [RATE_W-1:0]  turn_rate_i,
  input  lim_cfg_t                  lim_cfg_i,
  input  logic                      out_full_i,
  output logic                      ready_o,
  output logic                      out_valid_o,
  output mid_item_t                 out_item_o
);

  localparam int unsigned FP_W = MAG_W + FOLD_RECIP_W;
  localparam int unsigned IP_W = NUM_W + INTERP_RECIP_W;

  logic [FRONT_STAGES-1:0] v_q;
  logic                    en;

  logic [ANGLE_W-1:0] ang_u;
  logic [RATE_W-1:0]  rate_u;
  logic [MAG_W-1:0]   mag;
  logic [RATE_W-1:0]  w_in;

  logic [RATE_W-1:0]  w_q [FRONT_STAGES];

  logic [MAG_W-1:0]    m1_q, m2_q;
  logic [FP_W-1:0]     fold_prod;
  logic [FOLD_Q_W-1:0] q2_q;
  logic [MAG_W-1:0]    rem, rem_c;
  logic [C_W-1:0]      c3_q;

  logic [NUM_W-1:0] ps4_q [NUM_LIMITS];
  logic [NUM_W-1:0] pd4_q [NUM_LIMITS];
  logic [NUM_W-1:0] n5_q  [NUM_LIMITS];
  logic [NUM_W-1:0] n6_q  [NUM_LIMITS];
  logic [LIM_W-1:0] qe6_q [NUM_LIMITS];
  logic [LIM_W-1:0] l7_q  [NUM_LIMITS];
  logic [IP_W-1:0]  iprod [NUM_LIMITS];
  logic [NUM_W-1:0] irem  [NUM_LIMITS];

  assign en          = !v_q[FRONT_STAGES-1] || !out_full_i;
  assign ready_o     = en;
  assign out_valid_o = v_q[FRONT_STAGES-1] && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[FRONT_STAGES-2:0], in_valid_i};
    end
  end

  // magnitudes; the most negative codes map onto themselves
  assign ang_u  = heading_angle_i;
  assign rate_u = turn_rate_i;
  assign mag    = ang_u[ANGLE_W-1] ? (~ang_u + 1'b1) : ang_u;
  assign w_in   = rate_u[RATE_W-1] ? (~rate_u + 1'b1) : rate_u;

  // fold: quotient estimate by reciprocal, one correction step after
  assign fold_prod = FP_W'(m1_q) * FP_W'(FOLD_RECIP);
  assign rem       = m2_q - MAG_W'(q2_q) * MAG_W'(SECTOR_UNITS);
  assign rem_c     = (rem >= MAG_W'(SECTOR_UNITS)) ? rem - MAG_W'(SECTOR_UNITS) : rem;

  always_comb begin
    for (int k = 0; k < NUM_LIMITS; k++) begin
      iprod[k] = IP_W'(n5_q[k]) * IP_W'(INTERP_RECIP);
      irem[k]  = n6_q[k] - NUM_W'(qe6_q[k]) * NUM_W'(SECTOR_UNITS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_q[0] <= w_in;
      for (int i = 1; i < FRONT_STAGES; i++) begin
        w_q[i] <= w_q[i-1];
      end
      m1_q <= mag;
      m2_q <= m1_q;
      q2_q <= fold_prod[MAG_W +: FOLD_Q_W];
      c3_q <= (m2_q <= MAG_W'(SECTOR_UNITS)) ? C_W'(m2_q) : C_W'(rem_c);
      for (int k = 0; k < NUM_LIMITS; k++) begin
        ps4_q[k] <= NUM_W'(lim_cfg_i[k].straight) * NUM_W'(C_W'(SECTOR_UNITS) - c3_q);
        pd4_q[k] <= NUM_W'(lim_cfg_i[k].diagonal) * NUM_W'(c3_q);
        n5_q[k]  <= ps4_q[k] + pd4_q[k];
        n6_q[k]  <= n5_q[k];
        qe6_q[k] <= iprod[k][NUM_W +: LIM_W];
        l7_q[k]  <= qe6_q[k] + LIM_W'(irem[k] >= NUM_W'(SECTOR_UNITS));
      end
    end
  end

  always_comb begin
    out_item_o.w = w_q[FRONT_STAGES-1];
    for (int k = 0; k < NUM_LIMITS; k++) begin
      out_item_o.lim[k] = l7_q[k];
    end
  end

endmodule

/* sv/hdml_mq.sv */
// small queue between the front and back pipelines
module hdml_mq import hdml_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  mid_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output mid_item_t item_o
);

  mid_item_t            mem_q [MQ_DEPTH];
  logic [MQ_PTR_W-1:0]  wr_q, rd_q;
  logic [MQ_CNT_W-1:0]  cnt_q;

  assign full_o  = (cnt_q == MQ_CNT_W'(MQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + MQ_CNT_W'(push_i) - MQ_CNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

/* sv/hdml_back.sv */
// back pipeline: turn rate scaling through a bit-per-stage divider
module hdml_back import hdml_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  mid_item_t         in_item_i,
  output logic              ready_o,
  input  logic [LIM_W-1:0]  turn_rate_limit_i,
  input  logic              pop_i,
  output logic              empty_o,
  output out_item_t         out_item_o
);

  localparam int unsigned P_W = 2 * LIM_W;

  logic [DIV_STEPS:0] v_q;
  logic               en;

  logic [LIM_W-1:0] dv;
  logic [LIM_W-1:0] factor;
  logic [P_W-1:0]   prod [NUM_LIMITS];

  logic [LIM_W-1:0] rem_q [DIV_STEPS+1][NUM_LIMITS];
  logic [LIM_W-1:0] sr_q  [DIV_STEPS+1][NUM_LIMITS];
  logic [LIM_W-1:0] rem_d [DIV_STEPS+1][NUM_LIMITS];
  logic [LIM_W-1:0] sr_d  [DIV_STEPS+1][NUM_LIMITS];

  out_item_t            oq_mem_q [OQ_DEPTH];
  out_item_t            res;
  logic [OQ_PTR_W-1:0]  oq_wr_q, oq_rd_q;
  logic [OQ_CNT_W-1:0]  oq_cnt_q;
  logic                 oq_push, oq_pop;

  assign en      = !v_q[DIV_STEPS] || (oq_cnt_q != OQ_CNT_W'(OQ_DEPTH));
  assign ready_o = en;
  assign oq_push = v_q[DIV_STEPS] && en;
  assign oq_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[DIV_STEPS-1:0], in_valid_i};
    end
  end

  // zero limit means no scaling: divide the bare limit by one
  always_comb begin
    if (turn_rate_limit_i == '0) begin
      dv     = LIM_W'(1);
      factor = LIM_W'(1);
    end else if (in_item_i.w >= turn_rate_limit_i) begin
      dv     = turn_rate_limit_i;
      factor = '0;
    end else begin
      dv     = turn_rate_limit_i;
      factor = turn_rate_limit_i - in_item_i.w;
    end
    for (int k = 0; k < NUM_LIMITS; k++) begin
      prod[k] = P_W'(in_item_i.lim[k]) * P_W'(factor);
    end
  end

  // upper half of the product is already below the divisor,
  // so one quotient bit per stage over the lower half
  always_comb begin
    logic [LIM_W:0] t;
    logic           ge;
    t  = '0;
    ge = 1'b0;
    for (int k = 0; k < NUM_LIMITS; k++) begin
      rem_d[0][k] = prod[k][P_W-1:LIM_W];
      sr_d[0][k]  = prod[k][LIM_W-1:0];
    end
    for (int j = 0; j < DIV_STEPS; j++) begin
      for (int k = 0; k < NUM_LIMITS; k++) begin
        t  = {rem_q[j][k], sr_q[j][k][LIM_W-1]};
        ge = (t >= {1'b0, dv});
        rem_d[j+1][k] = ge ? LIM_W'(t - {1'b0, dv}) : t[LIM_W-1:0];
        sr_d[j+1][k]  = {sr_q[j][k][LIM_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q <= rem_d;
      sr_q  <= sr_d;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_LIMITS; k++) begin
      res.lim[k] = sr_q[DIV_STEPS][k];
    end
  end

  // output queue keeps the pipeline moving while a result waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_q <= oq_wr_q + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_q <= oq_rd_q + 1'b1;
      end
      oq_cnt_q <= oq_cnt_q + OQ_CNT_W'(oq_push) - OQ_CNT_W'(oq_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_mem_q[oq_wr_q] <= res;
    end
  end

  assign empty_o    = (oq_cnt_q == '0);
  assign out_item_o = oq_mem_q[oq_rd_q];

endmodule

/* sv/heading_dependent_motion_limits.sv */
// top level of the heading dependent motion limits block
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | push / full        | heading_angle_i, turn_rate_i
//  result   | empty / pop        | speed_limit_o, accel_limit_o, decel_limit_o
//  config   | cfg_we_i           | cfg_idx_i, cfg_wdata_i
//
// one item per cycle sustained while results are popped; a result passes 7
// front stages (fold and interpolation multipliers), the mid queue, 17 back
// stages (rate product and a 16-step one-bit-per-stage divider) and the
// output queue. reset zeroes the valid bits, queue pointers and config, not
// the data registers; no clearing pass. with pop held low the back halts once
// its output queue is full, the mid queue then fills and full rises.
`include "heading_dependent_motion_limits_macros.svh"

module heading_dependent_motion_limits import hdml_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic signed [ANGLE_W-1:0] heading_angle_i,
  input  logic signed [RATE_W-1:0]  turn_rate_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [LIM_W-1:0]          speed_limit_o,
  output logic [LIM_W-1:0]          accel_limit_o,
  output logic [LIM_W-1:0]          decel_limit_o,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [LIM_W-1:0]          cfg_wdata_i
);

  lim_cfg_t         lim_cfg_q;
  logic [LIM_W-1:0] rate_lim_q;

  logic      front_ready, in_xfer;
  logic      mid_push, mid_full, mid_pop, mid_empty, back_ready;
  mid_item_t mid_in, mid_out;
  out_item_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_cfg_q  <= '0;
      rate_lim_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SPEED_STRAIGHT: lim_cfg_q[LIM_SPEED].straight <= cfg_wdata_i;
        REG_SPEED_DIAGONAL: lim_cfg_q[LIM_SPEED].diagonal <= cfg_wdata_i;
        REG_ACCEL_STRAIGHT: lim_cfg_q[LIM_ACCEL].straight <= cfg_wdata_i;
        REG_ACCEL_DIAGONAL: lim_cfg_q[LIM_ACCEL].diagonal <= cfg_wdata_i;
        REG_DECEL_STRAIGHT: lim_cfg_q[LIM_DECEL].straight <= cfg_wdata_i;
        REG_DECEL_DIAGONAL: lim_cfg_q[LIM_DECEL].diagonal <= cfg_wdata_i;
        REG_TURN_RATE_LIM:  rate_lim_q                    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign full    = !front_ready;
  assign in_xfer = push && front_ready;

  hdml_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_xfer),
    .heading_angle_i (heading_angle_i),
    .turn_rate_i     (turn_rate_i),
    .lim_cfg_i       (lim_cfg_q),
    .out_full_i      (mid_full),
    .ready_o         (front_ready),
    .out_valid_o     (mid_push),
    .out_item_o      (mid_in)
  );

  hdml_mq u_mq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .item_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .empty_o (mid_empty),
    .item_o  (mid_out)
  );

  assign mid_pop = !mid_empty && back_ready;

  hdml_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (!mid_empty),
    .in_item_i         (mid_out),
    .ready_o           (back_ready),
    .turn_rate_limit_i (rate_lim_q),
    .pop_i             (pop),
    .empty_o           (empty),
    .out_item_o        (res)
  );

  assign speed_limit_o = res.lim[LIM_SPEED];
  assign accel_limit_o = res.lim[LIM_ACCEL];
  assign decel_limit_o = res.lim[LIM_DECEL];

  `HDML_NEVER(a_mid_no_overflow, mid_push && mid_full && !mid_pop)
  `HDML_ASSERT(a_mid_no_underflow, mid_pop |-> !mid_empty)
  `HDML_ASSERT(a_front_stall_on_full, (mid_full && !back_ready) |-> !mid_push)

endmodule
